@@ rtl/udsmc_pkg.sv @@
// Shared types, command codes and helpers for the DC and stepper motor command block.
// No dependencies; imported by uart_dc_and_stepper_motor_control.
`default_nettype none

package udsmc_pkg;

   // Channel widths
   localparam int unsigned REQ_DATA_W = 8;   // cmd_byte
   localparam int unsigned REQ_USER_W = 1;   // action
   localparam int unsigned RSP_DATA_W = 16;  // 15 payload bits, padded to two bytes

   // Item kind carried on req_tuser
   localparam logic ACTION_CMD  = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   // ASCII command codes
   localparam logic [7:0] CMD_DC_FWD     = 8'h44;  // 'D'
   localparam logic [7:0] CMD_DC_REV     = 8'h41;  // 'A'
   localparam logic [7:0] CMD_DUTY_W     = 8'h57;  // 'W'
   localparam logic [7:0] CMD_DUTY_S     = 8'h53;  // 'S'
   localparam logic [7:0] CMD_DC_STOP    = 8'h5A;  // 'Z'
   localparam logic [7:0] CMD_STEP_FWD   = 8'h48;  // 'H'
   localparam logic [7:0] CMD_STEP_REV   = 8'h46;  // 'F'
   localparam logic [7:0] CMD_DWELL_DOWN = 8'h54;  // 'T'
   localparam logic [7:0] CMD_DWELL_UP   = 8'h47;  // 'G'
   localparam logic [7:0] CMD_STEP_STOP  = 8'h58;  // 'X'

   // Duty and dwell limits
   localparam logic [7:0] DUTY_STEP    = 8'd10;
   localparam logic [7:0] DUTY_MAX     = 8'd240;
   localparam logic [7:0] DUTY_MIN     = 8'd10;
   localparam logic [7:0] DUTY_REVERSE = 8'd250;
   localparam logic [2:0] DWELL_MIN    = 3'd1;
   localparam logic [2:0] DWELL_MAX    = 3'd5;
   localparam logic [2:0] DWELL_RESET  = 3'd6;

   typedef enum logic [1:0] {
      DC_IDLE = 2'd0,
      DC_FWD  = 2'd1,
      DC_REV  = 2'd2
   } dc_mode_type;

   typedef enum logic [1:0] {
      STEP_STOPPED = 2'd0,
      STEP_FWD     = 2'd1,
      STEP_REV     = 2'd2
   } step_mode_type;

   function automatic logic [7:0] duty_up(input logic [7:0] d);
      logic [8:0] n;
      n = {1'b0, d} + {1'b0, DUTY_STEP};
      return (n >= {1'b0, DUTY_MAX}) ? DUTY_MAX : n[7:0];
   endfunction

   function automatic logic [7:0] duty_down(input logic [7:0] d);
      return (d <= (DUTY_MIN + DUTY_STEP)) ? DUTY_MIN : (d - DUTY_STEP);
   endfunction

   // Forward half-step coil table
   function automatic logic [3:0] half_step(input logic [2:0] idx);
      logic [3:0] pat;
      unique case (idx)
         3'd0:    pat = 4'h1;
         3'd1:    pat = 4'h3;
         3'd2:    pat = 4'h2;
         3'd3:    pat = 4'h6;
         3'd4:    pat = 4'h4;
         3'd5:    pat = 4'hC;
         3'd6:    pat = 4'h8;
         default: pat = 4'h9;
      endcase
      return pat;
   endfunction

endpackage

`default_nettype wire

@@ rtl/uart_dc_and_stepper_motor_control.sv @@
// DC motor and half-step stepper command block: top level, single module.
// Depends on udsmc_pkg (codes, limits, duty helpers, coil table).
//
// Usage
//   req channel: one transaction is either a received command byte
//     (req_tuser = 0, byte on req_tdata) or a one-millisecond tick (req_tuser = 1,
//     req_tdata ignored).
//   rsp channel: exactly one transaction per request, showing the outputs after
//     that request: duty, direction pin, coil bits and stepper mode.
//   Path: a request accepted into the input register is decoded there and lands
//     in the result register, which drives its response; a full result register
//     that waits on rsp_tready holds the request in the input register.
//   Throughput: one transaction per cycle while rsp_tready is high. The state update
//     for an item is one pass of decode and clamp logic from the input register to
//     the state and result registers, so the next item sees the new state straight away.
//   Stall: while rsp_tready is low and a response waits, one more request is
//     still taken into the input register; req_tready then drops until the
//     response is taken. Nothing is lost or repeated.
//   Reset: synchronous, active high. Duty 0, DC idle, direction 0, stepper
//     stopped, dwell 6 ms, counters and coils 0; both pipeline stages empty.
`default_nettype none

module uart_dc_and_stepper_motor_control (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [udsmc_pkg::REQ_DATA_W-1:0]  req_tdata,   // [7:0] cmd_byte
   input  wire  [udsmc_pkg::REQ_USER_W-1:0]  req_tuser,   // [0] action
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [udsmc_pkg::RSP_DATA_W-1:0]  rsp_tdata    // [7:0] pwm_duty, [8] motor_dir,
                                                           // [12:9] coil_pattern,
                                                           // [14:13] stepper_running, [15] 0
);

   import udsmc_pkg::*;

   // Input register
   logic                  req_valid_ff, req_valid_in;
   logic                  req_action_ff;
   logic [7:0]            req_cmd_ff;

   // Result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Block state
   logic [7:0]            duty_level_ff, duty_level_in;
   dc_mode_type           dc_mode_ff, dc_mode_in;
   logic                  dir_pin_ff, dir_pin_in;
   step_mode_type         step_mode_ff, step_mode_in;
   logic [2:0]            dwell_ms_ff, dwell_ms_in;
   logic [2:0]            dwell_count_ff, dwell_count_in;
   logic [2:0]            phase_index_ff, phase_index_in;
   logic [3:0]            coil_reg_ff, coil_reg_in;

   logic                  req_fire;
   logic                  stage_advance;
   logic [2:0]            tick_idx;
   logic [2:0]            count_inc;

   assign req_fire      = req_tvalid && req_tready;
   // the input stage moves on when the result register is free or being emptied
   assign stage_advance = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready    = !req_valid_ff || stage_advance;

   assign req_valid_in  = req_fire ? 1'b1 : (stage_advance ? 1'b0 : req_valid_ff);
   assign rsp_valid_in  = stage_advance ? 1'b1
                        : ((rsp_valid_ff && rsp_tready) ? 1'b0 : rsp_valid_ff);

   // reverse running reads the table back to front
   assign tick_idx  = (step_mode_ff == STEP_REV) ? (3'd7 - phase_index_ff) : phase_index_ff;
   assign count_inc = dwell_count_ff + 3'd1;

   // Next-state decode for the item in the input register
   always_comb begin
      duty_level_in  = duty_level_ff;
      dc_mode_in     = dc_mode_ff;
      dir_pin_in     = dir_pin_ff;
      step_mode_in   = step_mode_ff;
      dwell_ms_in    = dwell_ms_ff;
      dwell_count_in = dwell_count_ff;
      phase_index_in = phase_index_ff;
      coil_reg_in    = coil_reg_ff;

      if (stage_advance) begin
         if (req_action_ff == ACTION_CMD) begin
            unique case (req_cmd_ff)
               CMD_DC_FWD: begin
                  duty_level_in = 8'd0;
                  dc_mode_in    = DC_FWD;
                  dir_pin_in    = 1'b0;
               end
               CMD_DC_REV: begin
                  duty_level_in = DUTY_REVERSE;
                  dc_mode_in    = DC_REV;
                  dir_pin_in    = 1'b1;
               end
               CMD_DUTY_W: begin
                  if (dc_mode_ff == DC_FWD) begin
                     duty_level_in = duty_up(duty_level_ff);
                  end else if (dc_mode_ff == DC_REV) begin
                     duty_level_in = duty_down(duty_level_ff);
                  end
               end
               CMD_DUTY_S: begin
                  if (dc_mode_ff == DC_FWD) begin
                     duty_level_in = duty_down(duty_level_ff);
                  end else if (dc_mode_ff == DC_REV) begin
                     duty_level_in = duty_up(duty_level_ff);
                  end
               end
               CMD_DC_STOP: begin
                  duty_level_in = 8'd0;
                  dir_pin_in    = 1'b0;
                  dc_mode_in    = DC_IDLE;
               end
               CMD_STEP_FWD, CMD_STEP_REV: begin
                  step_mode_in   = (req_cmd_ff == CMD_STEP_FWD) ? STEP_FWD : STEP_REV;
                  coil_reg_in    = 4'h0;
                  phase_index_in = 3'd0;
                  dwell_count_in = 3'd0;
               end
               CMD_DWELL_DOWN: begin
                  dwell_ms_in = (dwell_ms_ff <= (DWELL_MIN + 3'd1)) ? DWELL_MIN
                                                                    : (dwell_ms_ff - 3'd1);
               end
               CMD_DWELL_UP: begin
                  dwell_ms_in = ({1'b0, dwell_ms_ff} + 4'd1 >= {1'b0, DWELL_MAX}) ? DWELL_MAX
                                                                 : (dwell_ms_ff + 3'd1);
               end
               CMD_STEP_STOP: begin
                  step_mode_in = STEP_STOPPED;
               end
               default: begin
               end
            endcase
         end else if (step_mode_ff == STEP_FWD || step_mode_ff == STEP_REV) begin
            // new coil pattern at the start of each dwell
            if (dwell_count_ff == 3'd0) begin
               coil_reg_in = half_step(tick_idx);
            end
            if (count_inc >= dwell_ms_ff) begin
               dwell_count_in = 3'd0;
               phase_index_in = phase_index_ff + 3'd1;
            end else begin
               dwell_count_in = count_inc;
            end
         end
      end

      rsp_data_in = stage_advance
                  ? {1'b0, step_mode_in, coil_reg_in, dir_pin_in, duty_level_in}
                  : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         duty_level_ff  <= 8'd0;
         dc_mode_ff     <= DC_IDLE;
         dir_pin_ff     <= 1'b0;
         step_mode_ff   <= STEP_STOPPED;
         dwell_ms_ff    <= DWELL_RESET;
         dwell_count_ff <= 3'd0;
         phase_index_ff <= 3'd0;
         coil_reg_ff    <= 4'h0;
      end else begin
         req_valid_ff   <= req_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         duty_level_ff  <= duty_level_in;
         dc_mode_ff     <= dc_mode_in;
         dir_pin_ff     <= dir_pin_in;
         step_mode_ff   <= step_mode_in;
         dwell_ms_ff    <= dwell_ms_in;
         dwell_count_ff <= dwell_count_in;
         phase_index_ff <= phase_index_in;
         coil_reg_ff    <= coil_reg_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_action_ff <= req_tuser[0];
         req_cmd_ff    <= req_tdata;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      duty_level_ff <= DUTY_REVERSE)
      else $error("duty above reverse level");

   a_dwell_range: assert property (@(posedge clock) disable iff (reset)
      dwell_ms_ff >= DWELL_MIN && dwell_ms_ff <= DWELL_RESET)
      else $error("dwell out of range");

   // the counter stays below the reset dwell of six, the largest dwell value
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      dwell_count_ff < DWELL_RESET)
      else $error("dwell counter out of range");

   a_dir_follows_mode: assert property (@(posedge clock) disable iff (reset)
      dir_pin_ff == (dc_mode_ff == DC_REV))
      else $error("direction pin disagrees with DC mode");

   a_rsp_drains: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !req_valid_ff |=> !rsp_tvalid)
      else $error("response repeated");

endmodule

`default_nettype wire
